@@ hdl/gsrd_pkg.sv @@
package gsrd_pkg;

   localparam int GLYPH_LIMIT_DEF = 256;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_HEIGHT = 2'd1;

   localparam logic ACT_START  = 1'b0;
   localparam logic ACT_STREAM = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] glyph_index;
      logic [7:0] data_byte;
   } gsrd_req_type;

   typedef struct packed {
      logic        pixel_write;
      logic [23:0] pixel_address;
      logic [2:0]  pixel_color;
      logic        glyph_done;
   } gsrd_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start;
      logic load_w;
      logic load_h;
      logic load_x;
      logic load_y;
      logic skip;
      logic base1;
      logic base2;
      logic prod;
      logic emit_pixel;
      logic emit_end;
   } gsrd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic below_limit;
      logic skip_end;
      logic adv_end;
   } gsrd_status_type;

   typedef struct packed {
      logic [8:0] col;
      logic [7:0] row;
      logic       fin;
   } gsrd_wrap_type;

endpackage

@@ hdl/gsrd_ctrl.sv @@
module gsrd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  gsrd_pkg::gsrd_status_type status,
   output gsrd_pkg::gsrd_cmd_type    cmd
);
   import gsrd_pkg::*;

   typedef enum logic [5:0] {
      ST_WAIT  = 6'b000001,
      ST_BASE1 = 6'b000010,
      ST_BASE2 = 6'b000100,
      ST_PROD  = 6'b001000,
      ST_PIXEL = 6'b010000,
      ST_END   = 6'b100000
   } state_type;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_W    = 6'b000010,
      PH_H    = 6'b000100,
      PH_X    = 6'b001000,
      PH_Y    = 6'b010000,
      PH_RUN  = 6'b100000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_START) begin
                  if (status.below_limit) begin
                     cmd.start = 1'b1;
                     phase_in  = PH_W;
                     state_in  = ST_BASE1;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_W: begin
                        cmd.load_w = 1'b1;
                        phase_in   = PH_H;
                     end
                     PH_H: begin
                        cmd.load_h = 1'b1;
                        phase_in   = PH_X;
                     end
                     PH_X: begin
                        cmd.load_x = 1'b1;
                        phase_in   = PH_Y;
                     end
                     PH_Y: begin
                        cmd.load_y = 1'b1;
                        phase_in   = PH_RUN;
                     end
                     PH_RUN: begin
                        cmd.skip = 1'b1;
                        if (status.skip_end) begin
                           phase_in = PH_IDLE;
                           state_in = ST_END;
                        end else begin
                           state_in = ST_PROD;
                        end
                     end
                     PH_IDLE: begin
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_BASE1: begin
            cmd.base1 = 1'b1;
            state_in  = ST_BASE2;
         end
         ST_BASE2: begin
            cmd.base2 = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_PIXEL;
         end
         ST_PIXEL: begin
            if (out_free) begin
               cmd.emit_pixel = 1'b1;
               if (status.adv_end) begin
                  phase_in = PH_IDLE;
               end
               state_in = ST_WAIT;
            end
         end
         ST_END: begin
            if (out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit_pixel || cmd.emit_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/gsrd_dp.sv @@
module gsrd_dp #(
   parameter int GLYPH_LIMIT = gsrd_pkg::GLYPH_LIMIT_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  gsrd_pkg::gsrd_req_type                     req_payload,
   output gsrd_pkg::gsrd_rsp_type                     rsp_payload,
   input  logic                                       csr_valid,
   input  logic [gsrd_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [gsrd_pkg::CSR_DATA_WIDTH-1:0]        csr_data,
   input  gsrd_pkg::gsrd_cmd_type                     cmd,
   output gsrd_pkg::gsrd_status_type                  status
);
   import gsrd_pkg::*;

   localparam logic [8:0] LIMIT = 9'(GLYPH_LIMIT);

   logic [7:0]   cell_w_ff, cell_w_in;
   logic [7:0]   cell_h_ff, cell_h_in;
   logic [7:0]   gidx_ff;
   logic [7:0]   glyph_w_ff, glyph_h_ff, off_x_ff, off_y_ff;
   logic [8:0]   column_ff;
   logic [7:0]   row_ff;
   logic [2:0]   color_ff;
   logic [15:0]  prod1_ff;
   logic [23:0]  base_ff;
   logic [16:0]  prod_ff;
   logic [9:0]   colsum_ff;
   gsrd_rsp_type rsp_ff;

   logic [8:0]    col_skip;
   logic [8:0]    ysum;
   gsrd_wrap_type skip_wrap, adv_wrap;

   // single wrap of the column into the next row
   function automatic gsrd_wrap_type wrap_once(input logic [8:0] col, input logic [7:0] row,
                                               input logic [7:0] w, input logic [7:0] h);
      gsrd_wrap_type r;
      r.col = col;
      r.row = row;
      r.fin = 1'b0;
      if (col >= {1'b0, w}) begin
         r.col = col - {1'b0, w};
         r.row = row + 8'd1;
         r.fin = (r.row >= h);
      end
      return r;
   endfunction

   assign col_skip  = column_ff + 9'(req_payload.data_byte[7:3]);
   assign skip_wrap = wrap_once(col_skip, row_ff, glyph_w_ff, glyph_h_ff);
   assign adv_wrap  = wrap_once(column_ff + 9'd1, row_ff, glyph_w_ff, glyph_h_ff);
   assign ysum      = {1'b0, off_y_ff} + {1'b0, row_ff};

   assign status.below_limit = ({1'b0, req_payload.glyph_index} < LIMIT);
   assign status.skip_end    = skip_wrap.fin;
   assign status.adv_end     = adv_wrap.fin;

   assign rsp_payload = rsp_ff;

   always_comb begin
      cell_w_in = cell_w_ff;
      cell_h_in = cell_h_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CELL_WIDTH:  cell_w_in = csr_data;
            CSR_CELL_HEIGHT: cell_h_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_w_ff <= '0;
         cell_h_ff <= '0;
      end else begin
         cell_w_ff <= cell_w_in;
         cell_h_ff <= cell_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         gidx_ff   <= req_payload.glyph_index;
         column_ff <= '0;
         row_ff    <= '0;
      end
      if (cmd.load_w) glyph_w_ff <= req_payload.data_byte;
      if (cmd.load_h) glyph_h_ff <= req_payload.data_byte;
      if (cmd.load_x) off_x_ff   <= req_payload.data_byte;
      if (cmd.load_y) off_y_ff   <= req_payload.data_byte;
      if (cmd.skip) begin
         column_ff <= skip_wrap.col;
         row_ff    <= skip_wrap.row;
         color_ff  <= req_payload.data_byte[2:0];
      end
      if (cmd.base1) prod1_ff <= 16'(gidx_ff) * 16'(cell_w_ff);
      if (cmd.base2) base_ff  <= 24'(prod1_ff) * 24'(cell_h_ff);
      if (cmd.prod) begin
         prod_ff   <= 17'(ysum) * 17'(cell_w_ff);
         colsum_ff <= 10'(off_x_ff) + 10'(column_ff);
      end
      if (cmd.emit_pixel) begin
         rsp_ff.pixel_write   <= 1'b1;
         rsp_ff.pixel_address <= base_ff + 24'(prod_ff) + 24'(colsum_ff);
         rsp_ff.pixel_color   <= color_ff;
         rsp_ff.glyph_done    <= adv_wrap.fin;
         column_ff            <= adv_wrap.col;
         row_ff               <= adv_wrap.row;
      end
      if (cmd.emit_end) begin
         rsp_ff.pixel_write   <= 1'b0;
         rsp_ff.pixel_address <= '0;
         rsp_ff.pixel_color   <= '0;
         rsp_ff.glyph_done    <= 1'b1;
      end
   end

endmodule

@@ hdl/glyph_skip_run_decoder.sv @@
// Glyph skip-run decoder: turns a compressed glyph stream into pixel writes.
// req_ channel: one item per transfer. action 0 starts a glyph (glyph_index),
// action 1 carries one stream byte: four header bytes, then control bytes.
// rsp_ channel: at most one result per control byte (pixel and/or done).
// csr_ channel: writes cell_width (index 0) and cell_height (index 1); always
// ready, to be used only while the decoder is idle.
// Steps, from transfer to the next req_ready: none for a header byte or an
// ignored item; BASE1 and BASE2 for a start (two-step multiply for the cell
// base); PROD (row product, column sum) and PIXEL (add of base, row product
// and column) for a control byte, or just END when the skip ends the glyph.
// The result sits in an output register; a new item is taken while it
// waits. If rsp_ready stays low, the next control byte holds in its final
// step until the register drains, and req_ready stays low meanwhile.
// Reset (synchronous) clears the cell width and height, leaves the decoder
// idle with no glyph open, and drops rsp_valid; other registers keep values.
module glyph_skip_run_decoder #(
   parameter int GLYPH_LIMIT = gsrd_pkg::GLYPH_LIMIT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gsrd_pkg::gsrd_req_type               req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gsrd_pkg::gsrd_rsp_type               rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gsrd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gsrd_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import gsrd_pkg::*;

   gsrd_cmd_type    cmd;
   gsrd_status_type status;

   assign csr_ready = 1'b1;

   gsrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_payload.action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   gsrd_dp #(
      .GLYPH_LIMIT (GLYPH_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

@@ hdl/gsrd_checker.sv @@
module gsrd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input gsrd_pkg::gsrd_req_type req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input gsrd_pkg::gsrd_rsp_type rsp_payload
);
   import gsrd_pkg::*;

   // result stays offered while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // a result without a pixel can only be the end of a glyph, with empty fields
   a_no_pixel_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.pixel_write |->
         rsp_payload.glyph_done && rsp_payload.pixel_address == 24'd0 &&
         rsp_payload.pixel_color == 3'd0)
      else $error("empty result without glyph_done");

   // a start transfer never produces a result
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.action == ACT_START && !rsp_valid |=> !rsp_valid)
      else $error("result after start transfer");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind glyph_skip_run_decoder gsrd_checker u_gsrd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ sim/tb_glyph_skip_run_decoder.sv @@
module tb_glyph_skip_run_decoder;
   import gsrd_pkg::*;

   localparam int SEG_ITEMS   = 240;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [2:0] {
      DEC_IDLE, DEC_WIDTH, DEC_HEIGHT, DEC_XOFF, DEC_YOFF, DEC_RUN
   } dec_phase_type;

   typedef struct packed {
      logic                       is_csr;
      logic [CSR_INDEX_WIDTH-1:0] csr_index;
      logic [CSR_DATA_WIDTH-1:0]  csr_data;
      gsrd_req_type               item;
      logic                       typed;
      logic                       has;
      gsrd_rsp_type               want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   gsrd_req_type               req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   gsrd_rsp_type               rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_CELL_WIDTH;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // expectation attached to the item on offer
   logic         cur_typed = 1'b0;
   logic         cur_has = 1'b0;
   gsrd_rsp_type cur_want = '0;

   // decoder state as predicted
   logic [7:0]    cell_w = '0;
   logic [7:0]    cell_h = '0;
   dec_phase_type gl_phase = DEC_IDLE;
   logic [7:0]    gl_w = '0;
   logic [7:0]    gl_h = '0;
   logic [7:0]    gl_x = '0;
   logic [7:0]    gl_y = '0;
   logic [8:0]    gl_col = '0;
   logic [7:0]    gl_row = '0;
   logic [23:0]   gl_base = '0;

   gsrd_rsp_type   pixel_queue[$];
   script_row_type script[$];

   int req_idle_pct = 17;
   int rsp_idle_pct = 83;
   int error_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int writes_expected = 0;
   int ends_expected = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   bit hold_used = 1'b0;
   bit hold_go = 1'b0;

   glyph_skip_run_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic log_fault(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // one wrap of the column into the next row; 1 when the glyph is finished
   function automatic bit row_wrap();
      if (gl_col >= {1'b0, gl_w}) begin
         gl_col = gl_col - {1'b0, gl_w};
         gl_row = gl_row + 8'd1;
         return gl_row >= gl_h;
      end
      return 1'b0;
   endfunction

   function automatic bit predict_pixel(input gsrd_req_type item, output gsrd_rsp_type px);
      logic [31:0] prod;
      logic [31:0] addr;
      px = '0;
      if (item.action == ACT_START) begin
         if (int'(item.glyph_index) < GLYPH_LIMIT_DEF) begin
            prod = 32'(item.glyph_index) * 32'(cell_w) * 32'(cell_h);
            gl_base = prod[23:0];
            gl_col = '0;
            gl_row = '0;
            gl_phase = DEC_WIDTH;
         end
         return 1'b0;
      end
      case (gl_phase)
         DEC_WIDTH: begin
            gl_w = item.data_byte;
            gl_phase = DEC_HEIGHT;
            return 1'b0;
         end
         DEC_HEIGHT: begin
            gl_h = item.data_byte;
            gl_phase = DEC_XOFF;
            return 1'b0;
         end
         DEC_XOFF: begin
            gl_x = item.data_byte;
            gl_phase = DEC_YOFF;
            return 1'b0;
         end
         DEC_YOFF: begin
            gl_y = item.data_byte;
            gl_phase = DEC_RUN;
            return 1'b0;
         end
         DEC_RUN: begin
         end
         default: begin
            return 1'b0;
         end
      endcase
      gl_col = gl_col + 9'(item.data_byte[7:3]);
      if (row_wrap()) begin
         gl_phase = DEC_IDLE;
         px.glyph_done = 1'b1;
         return 1'b1;
      end
      addr = 32'(gl_base) + (32'(gl_y) + 32'(gl_row)) * 32'(cell_w) + 32'(gl_x) + 32'(gl_col);
      px.pixel_write   = 1'b1;
      px.pixel_address = addr[23:0];
      px.pixel_color   = item.data_byte[2:0];
      gl_col = gl_col + 9'd1;
      px.glyph_done = row_wrap();
      if (px.glyph_done) begin
         gl_phase = DEC_IDLE;
      end
      return 1'b1;
   endfunction

   function automatic script_row_type row_in(input logic act, input logic [7:0] gidx,
                                             input logic [7:0] db);
      script_row_type r;
      r = '0;
      r.item.action      = act;
      r.item.glyph_index = gidx;
      r.item.data_byte   = db;
      return r;
   endfunction

   // typed: no result expected
   function automatic script_row_type row_none(input logic act, input logic [7:0] gidx,
                                               input logic [7:0] db);
      script_row_type r;
      r = row_in(act, gidx, db);
      r.typed = 1'b1;
      return r;
   endfunction

   // typed: control byte with its result
   function automatic script_row_type row_px(input logic [7:0] db, input logic pw,
                                             input logic [23:0] addr, input logic [2:0] color,
                                             input logic done);
      script_row_type r;
      r = row_in(ACT_STREAM, 8'd0, db);
      r.typed = 1'b1;
      r.has   = 1'b1;
      r.want.pixel_write   = pw;
      r.want.pixel_address = addr;
      r.want.pixel_color   = color;
      r.want.glyph_done    = done;
      return r;
   endfunction

   function automatic script_row_type row_cfg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                              input logic [CSR_DATA_WIDTH-1:0] val);
      script_row_type r;
      r = '0;
      r.is_csr    = 1'b1;
      r.csr_index = idx;
      r.csr_data  = val;
      return r;
   endfunction

   // glyph-shaped random stream: start, header, control bytes, some stray bytes
   function automatic script_row_type random_row(ref int left, ref int hdr);
      logic [7:0] gidx;
      logic [7:0] db;
      gidx = 8'($urandom);
      db   = 8'($urandom);
      if (left == 0 || $urandom_range(99) < 2) begin
         left = $urandom_range(40, 4);
         hdr  = 0;
         return row_in(ACT_START, gidx, db);
      end
      left--;
      if (hdr < 4) begin
         case (hdr)
            0: db = ($urandom_range(9) == 0) ? db : 8'($urandom_range(12, 0));
            1: db = ($urandom_range(9) == 0) ? db : 8'($urandom_range(6, 0));
            default: begin
            end
         endcase
         hdr++;
      end else if ($urandom_range(3) != 0) begin
         db = {5'($urandom_range(3, 0)), db[2:0]};
      end
      return row_in(ACT_STREAM, gidx, db);
   endfunction

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixel_queue.size() != 0 || !req_ready || rsp_valid);
   endtask

   task automatic send_row(input script_row_type row);
      if (row.is_csr) begin
         wait_quiet();
         csr_valid <= 1'b1;
         csr_index <= row.csr_index;
         csr_data  <= row.csr_data;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
      end else begin
         if ($urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
         end
         req_valid   <= 1'b1;
         req_payload <= row.item;
         cur_typed   <= row.typed;
         cur_has     <= row.has;
         cur_want    <= row.want;
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // predictor and scoreboard
   always @(posedge clock) begin
      gsrd_rsp_type px;
      gsrd_rsp_type want_px;
      bit           has;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CELL_WIDTH:  cell_w = csr_data;
               CSR_CELL_HEIGHT: cell_h = csr_data;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            items_sent++;
            has = predict_pixel(req_payload, px);
            if (cur_typed) begin
               has = cur_has;
               px  = cur_want;
            end
            if (has) begin
               pixel_queue.push_back(px);
               if (px.pixel_write) writes_expected++;
               if (px.glyph_done) ends_expected++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pixel_queue.size() == 0) begin
               log_fault($sformatf("unexpected result w=%0b a=%06h c=%0d d=%0b",
                                   rsp_payload.pixel_write, rsp_payload.pixel_address,
                                   rsp_payload.pixel_color, rsp_payload.glyph_done));
            end else begin
               want_px = pixel_queue.pop_front();
               if (rsp_payload !== want_px) begin
                  log_fault($sformatf({"result %0d: expected w=%0b a=%06h c=%0d d=%0b,",
                                       " got w=%0b a=%06h c=%0d d=%0b"},
                                      results_seen,
                                      want_px.pixel_write, want_px.pixel_address,
                                      want_px.pixel_color, want_px.glyph_done,
                                      rsp_payload.pixel_write, rsp_payload.pixel_address,
                                      rsp_payload.pixel_color, rsp_payload.glyph_done));
               end
            end
         end
      end
   end

   // receiver, with one long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int seg;
      int n;
      int gen_left;
      int gen_hdr;
      int n_directed;

      gen_left = 0;
      gen_hdr  = 0;

      // byte before any start, then a glyph with zero cell size
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'h3C));
      script.push_back(row_none(ACT_START, 8'd3, 8'h00));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd4));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd2));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd1));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_px(8'h07, 1'b1, 24'd1, 3'd7, 1'b0));
      // large skip leaves the column past the width, pixel then glyph end
      script.push_back(row_px(8'hF8, 1'b1, 24'd29, 3'd0, 1'b1));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'h00));
      // 10 x 8 cells
      script.push_back(row_cfg(CSR_CELL_WIDTH, 8'd10));
      script.push_back(row_cfg(CSR_CELL_HEIGHT, 8'd8));
      script.push_back(row_none(ACT_START, 8'd2, 8'h00));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd3));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd1));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd2));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd1));
      script.push_back(row_px(8'h12, 1'b1, 24'd174, 3'd2, 1'b1));
      // glyph ends on the skip
      script.push_back(row_none(ACT_START, 8'd0, 8'h00));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd2));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd1));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_px(8'h10, 1'b0, 24'd0, 3'd0, 1'b1));
      // zero height
      script.push_back(row_none(ACT_START, 8'd1, 8'h00));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd5));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_none(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_px(8'h01, 1'b1, 24'd80, 3'd1, 1'b0));
      script.push_back(row_px(8'h22, 1'b0, 24'd0, 3'd0, 1'b1));
      // start mid-glyph aborts it
      script.push_back(row_in(ACT_START, 8'd4, 8'h00));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd6));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd3));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd1));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd1));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'h0B));
      script.push_back(row_in(ACT_START, 8'd5, 8'h00));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd2));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd2));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd0));
      repeat (5) script.push_back(row_in(ACT_STREAM, 8'd0, 8'h09));
      // zero width, short height
      script.push_back(row_in(ACT_START, 8'd6, 8'h00));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd3));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'h00));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'h05));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'h03));
      // largest cells, last glyph, widest fields
      script.push_back(row_cfg(CSR_CELL_WIDTH, 8'd255));
      script.push_back(row_cfg(CSR_CELL_HEIGHT, 8'd255));
      script.push_back(row_in(ACT_START, 8'd255, 8'h00));
      repeat (4) script.push_back(row_in(ACT_STREAM, 8'd0, 8'd255));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'hFF));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'hFF));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'hF8));
      // zero width, tall: the column runs past 511 and wraps
      script.push_back(row_in(ACT_START, 8'd7, 8'h00));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd0));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd255));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd3));
      script.push_back(row_in(ACT_STREAM, 8'd0, 8'd2));
      repeat (20) script.push_back(row_in(ACT_STREAM, 8'd0, 8'hFF));
      n_directed = script.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_row(script[i]);
      end

      for (seg = 0; seg < 3; seg++) begin
         case (seg)
            0: begin
               req_idle_pct = 17;
               rsp_idle_pct = 83;
            end
            1: begin
               req_idle_pct = 83;
               rsp_idle_pct = 17;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         send_row(row_cfg(CSR_CELL_WIDTH, 8'($urandom_range(40, 0))));
         send_row(row_cfg(CSR_CELL_HEIGHT, 8'($urandom_range(20, 0))));
         if (seg == 2) begin
            hold_go = 1'b1;
         end
         for (n = 0; n < SEG_ITEMS; n++) begin
            send_row(random_row(gen_left, gen_hdr));
         end
      end

      wait_quiet();

      $display("Covered %0d items (%0d directed rows) and %0d results: %0d pixel writes, %0d ends.",
               items_sent, n_directed, results_seen, writes_expected, ends_expected);
      $display("Three handshake mixes and a %0d-cycle receiver hold with the sender offering.",
               HOLD_CYCLES);
      if (error_count == 0 && pixel_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
